// ===== hw/rtl/srmc_pkg.sv =====
// srmc_pkg: shared constants and types for the stepper ramp mover.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package srmc_pkg;
    localparam int POSITION_BITS = 24;
    localparam int ANGLE_BITS    = 12;
    localparam int RAMP_DIVISOR  = 5;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 20;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_MOVE   = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_WORKING   = 3'd0,
        ST_TOLERANCE = 3'd1,
        ST_ZERO_CORR = 3'd2,
        ST_ITER_LIM  = 3'd3,
        ST_SENSOR    = 3'd4,
        ST_OPEN_DONE = 3'd5
    } status_t;

    localparam logic [CFG_IDX_BITS-1:0] REG_START_DELAY = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_DELAY   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CORR_DELAY  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_CORR    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ITER    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEPS_TURN  = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLOSED_LOOP = 3'd7;

    typedef struct packed {
        logic [1:0]                      opcode;
        logic signed [POSITION_BITS-1:0] target_steps;
        logic [ANGLE_BITS-1:0]           target_angle;
        logic [ANGLE_BITS-1:0]           measured_angle;
        logic                            sample_ok;
    } in_word_t;

    typedef struct packed {
        logic                            step_pulse;
        logic                            direction;
        logic                            busy_res;
        logic                            sample_request;
        logic signed [POSITION_BITS-1:0] position_steps;
        logic [2:0]                      status;
    } out_word_t;
endpackage
`default_nettype wire

// ===== hw/rtl/srmc_if.sv =====
// srmc_if: valid/ready channels carrying one srmc_pkg in_word_t or out_word_t.
// Depends on srmc_pkg for the word types.
`timescale 1ns / 1ps
`default_nettype none
interface srmc_in_if;
    logic                valid;
    logic                ready;
    srmc_pkg::in_word_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface srmc_out_if;
    logic                valid;
    logic                ready;
    srmc_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/stepper_ramp_move_with_correction.sv =====
// stepper_ramp_move_with_correction: one-joint trapezoid step generator with
// sensor correction. Depends on srmc_pkg and srmc_if.sv.
`timescale 1ns / 1ps
`default_nettype none
// channel   | dir | payload                                      | handshake
// in_ch     | in  | opcode, target_steps, target_angle, meas...  | valid/ready
// out_ch    | out | step_pulse, direction, busy_res, ..., status | valid/ready
// cfg       | in  | cfg_we, cfg_index[2:0], cfg_wdata[19:0]      | write enable
//
// Sequence: a tick, sample or ignored word passes accept, update and load.
// A ramp step, or a move that starts stepping, runs the shared shift-subtract
// unit: one restoring-division bit per cycle over 40 bits.
// A sample that starts a correction adds a rounding state, S_CORR.
// The result sits in an output register; the next word is taken while it
// waits, and only the load of the following result stalls on it.
// Reset clears the control state and presets the configuration registers.
module stepper_ramp_move_with_correction (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    srmc_in_if.sink                                   in_ch,
    srmc_out_if.source                                out_ch,
    input  wire logic                                 cfg_we,
    input  wire logic [srmc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [srmc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
    localparam int PB = srmc_pkg::POSITION_BITS;
    localparam int AB = srmc_pkg::ANGLE_BITS;
    localparam int DW = PB + 16;              // dividend width for k*(s-m)
    localparam int CW = $clog2(DW + 1);

    typedef enum logic [1:0] {PH_IDLE, PH_MOVE, PH_WAIT, PH_CORR} phase_t;
    typedef enum logic [2:0] {
        S_IN, S_EXEC, S_DIV, S_DIVEND, S_CORR, S_OUT
    } seq_t;

    // configuration
    logic [15:0] start_reg, min_reg, corr_delay_reg, max_corr_reg;
    logic [10:0] tol_reg;
    logic [7:0]  max_iter_reg;
    logic [19:0] spt_reg;
    logic        cl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg      <= 16'd5000;
            min_reg        <= 16'd1800;
            corr_delay_reg <= 16'd1500;
            tol_reg        <= 11'd57;
            max_corr_reg   <= 16'd2200;
            max_iter_reg   <= 8'd30;
            spt_reg        <= 20'd3200;
            cl_reg         <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                srmc_pkg::REG_START_DELAY: start_reg      <= cfg_wdata[15:0];
                srmc_pkg::REG_MIN_DELAY:   min_reg        <= cfg_wdata[15:0];
                srmc_pkg::REG_CORR_DELAY:  corr_delay_reg <= cfg_wdata[15:0];
                srmc_pkg::REG_TOLERANCE:   tol_reg        <= cfg_wdata[10:0];
                srmc_pkg::REG_MAX_CORR:    max_corr_reg   <= cfg_wdata[15:0];
                srmc_pkg::REG_MAX_ITER:    max_iter_reg   <= cfg_wdata[7:0];
                srmc_pkg::REG_STEPS_TURN:  spt_reg        <= cfg_wdata[19:0];
                default:                   cl_reg         <= cfg_wdata[0];
            endcase
        end
    end

    // state
    seq_t                 seq_reg;
    phase_t               phase_reg;
    srmc_pkg::in_word_t   w_reg;
    logic signed [PB-1:0] pos_reg;
    logic [PB-1:0]        n_reg, idx_reg;
    logic [PB-1:0]        ramp_reg;  // ramp length of the current move
    logic [15:0]          dly_reg;
    logic                 dir_reg, pulse_reg;
    logic [7:0]           iter_reg;
    logic [AB-1:0]        goal_reg;
    logic [2:0]           last_reg;
    // shared shift-subtract unit
    logic [DW-1:0]        num_reg;   // dividend, shifts out quotient bits
    logic [PB:0]          rem_reg;
    logic [PB-1:0]        den_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 ramp_div_reg; // dividing n by the ramp divisor
    logic [15:0]          base_reg;  // start delay for the ramp step
    logic                 up_reg;    // s >= m: subtract rounded-up quotient
    logic [AB+20-1:0]     prod_reg;
    logic                 corr_dir_reg;
    srmc_pkg::out_word_t  out_reg;
    logic                 ovalid_reg;

    localparam logic signed [PB-1:0] PMAX = {1'b0, {(PB-1){1'b1}}};
    localparam logic signed [PB-1:0] PMIN = {1'b1, {(PB-1){1'b0}}};
    localparam logic [AB:0] HALF = {2'b01, {(AB-1){1'b0}}};
    localparam logic signed [AB+1:0] HALF_S = {3'b001, {(AB-1){1'b0}}};
    localparam logic signed [AB+1:0] TURN_S = {2'b01, {AB{1'b0}}};

    // combinational helpers
    logic [PB-1:0] idx_inc;
    logic [PB:0]   rem_sh, rem_sub;
    logic signed [AB+1:0] err0, err;
    logic [AB:0]   err_mag;
    logic [PB:0]   diff;
    logic signed [PB:0] diff_s;
    logic [PB-1:0] ramp_k;
    logic [15:0]   ramp_span;
    logic [AB+19:0] corr_round, corr_steps;
    logic          is_step, ramp_div_go, move_go, corr_go;

    assign idx_inc  = idx_reg + PB'(1);
    assign rem_sh   = {rem_reg[PB-1:0], num_reg[DW-1]};
    assign rem_sub  = rem_sh - {1'b0, den_reg};
    assign err0 = $signed({2'b00, goal_reg}) - $signed({2'b00, w_reg.measured_angle});
    always_comb
    begin
        err = err0;
        if (err0 > HALF_S)
            err = err0 - TURN_S;
        else if (err0 < -HALF_S)
            err = err0 + TURN_S;
        err_mag = err[AB+1] ? (AB+1)'(-err) : (AB+1)'(err);
    end
    assign diff_s = $signed({w_reg.target_steps[PB-1], w_reg.target_steps})
                  - $signed({pos_reg[PB-1], pos_reg});
    assign diff = diff_s[PB] ? (PB+1)'(-diff_s) : (PB+1)'(diff_s);

    assign ramp_k    = (idx_inc < ramp_reg) ? idx_inc : n_reg - idx_inc;
    assign ramp_span = (start_reg >= min_reg) ? start_reg - min_reg : min_reg - start_reg;
    assign corr_round = (prod_reg + (AB+20)'(HALF)) >> AB;
    assign corr_steps = (corr_round > (AB+20)'(max_corr_reg)) ? (AB+20)'(max_corr_reg)
                                                              : corr_round;

    // where S_EXEC goes next
    assign is_step = w_reg.opcode == srmc_pkg::OP_TICK &&
                     (phase_reg == PH_MOVE || phase_reg == PH_CORR) && dly_reg <= 16'd1;
    assign ramp_div_go = is_step && !(idx_inc >= n_reg) && phase_reg == PH_MOVE &&
                         n_reg >= PB'(2) &&
                         (idx_inc < ramp_reg || idx_inc > n_reg - ramp_reg);
    assign move_go = w_reg.opcode == srmc_pkg::OP_MOVE && phase_reg == PH_IDLE &&
                     diff != '0;
    assign corr_go = w_reg.opcode == srmc_pkg::OP_SAMPLE && phase_reg == PH_WAIT &&
                     w_reg.sample_ok && err_mag > (AB+1)'(tol_reg);

    assign in_ch.ready  = (seq_reg == S_IN);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg    <= S_IN;
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            n_reg      <= '0;
            idx_reg    <= '0;
            ramp_reg   <= '0;
            dly_reg    <= '0;
            dir_reg    <= 1'b0;
            pulse_reg  <= 1'b0;
            iter_reg   <= '0;
            goal_reg   <= '0;
            last_reg   <= srmc_pkg::ST_WORKING;
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready && seq_reg != S_OUT)
                ovalid_reg <= 1'b0;
            unique case (seq_reg)
                S_IN:
                begin
                    pulse_reg <= 1'b0;
                    if (in_ch.valid && in_ch.ready)
                    begin
                        w_reg   <= in_ch.data;
                        seq_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    seq_reg <= (ramp_div_go || move_go) ? S_DIV
                             : corr_go ? S_CORR : S_OUT;
                    if (w_reg.opcode == srmc_pkg::OP_TICK &&
                        (phase_reg == PH_MOVE || phase_reg == PH_CORR))
                    begin
                        if (dly_reg > 16'd1)
                            dly_reg <= dly_reg - 16'd1;
                        else
                        begin
                            pulse_reg <= 1'b1;
                            if (dir_reg)
                            begin
                                if (pos_reg != PMAX) pos_reg <= pos_reg + PB'(1);
                            end
                            else if (pos_reg != PMIN)
                                pos_reg <= pos_reg - PB'(1);
                            idx_reg <= idx_inc;
                            if (idx_inc >= n_reg)
                            begin
                                dly_reg <= '0;
                                if (phase_reg == PH_MOVE)
                                begin
                                    iter_reg <= '0;
                                    if (!cl_reg)
                                    begin
                                        phase_reg <= PH_IDLE;
                                        last_reg  <= srmc_pkg::ST_OPEN_DONE;
                                    end
                                    else if (max_iter_reg == 8'd0)
                                    begin
                                        phase_reg <= PH_IDLE;
                                        last_reg  <= srmc_pkg::ST_ITER_LIM;
                                    end
                                    else
                                        phase_reg <= PH_WAIT;
                                end
                                else
                                begin
                                    iter_reg <= iter_reg + 8'd1;
                                    if (iter_reg + 8'd1 >= max_iter_reg)
                                    begin
                                        phase_reg <= PH_IDLE;
                                        last_reg  <= srmc_pkg::ST_ITER_LIM;
                                    end
                                    else
                                        phase_reg <= PH_WAIT;
                                end
                            end
                            else if (phase_reg == PH_CORR)
                                dly_reg <= (corr_delay_reg == 16'd0) ? 16'd1
                                                                     : corr_delay_reg;
                            else
                            begin
                                // ramp delay for step idx_inc of n_reg
                                priority if (n_reg < PB'(2))
                                    dly_reg <= (start_reg == 16'd0) ? 16'd1 : start_reg;
                                else if (idx_inc < ramp_reg ||
                                         idx_inc > n_reg - ramp_reg)
                                begin
                                    // k*(|s-m|) set up for the divider
                                    num_reg  <= {16'd0, ramp_k} * {{(PB-16){1'b0}}, ramp_span};
                                    den_reg  <= ramp_reg;
                                    rem_reg  <= '0;
                                    cnt_reg  <= '0;
                                    ramp_div_reg <= 1'b0;
                                    base_reg <= start_reg;
                                    up_reg   <= start_reg >= min_reg;
                                end
                                else
                                    dly_reg <= (min_reg == 16'd0) ? 16'd1 : min_reg;
                            end
                        end
                    end
                    else if (w_reg.opcode == srmc_pkg::OP_MOVE && phase_reg == PH_IDLE)
                    begin
                        goal_reg <= w_reg.target_angle;
                        if (diff == '0)
                        begin
                            // zero-length move: done at once, never corrects
                            phase_reg <= PH_IDLE;
                            last_reg  <= (cl_reg && max_iter_reg == 8'd0)
                                         ? srmc_pkg::ST_ITER_LIM : srmc_pkg::ST_OPEN_DONE;
                            if (cl_reg) iter_reg <= '0;
                        end
                        else
                        begin
                            last_reg  <= srmc_pkg::ST_WORKING;
                            dir_reg   <= !diff_s[PB];
                            n_reg     <= diff[PB-1:0];
                            idx_reg   <= '0;
                            dly_reg   <= (start_reg == 16'd0) ? 16'd1 : start_reg;
                            phase_reg <= PH_MOVE;
                            // ramp length n / RAMP_DIVISOR on the shared divider
                            num_reg   <= DW'(diff[PB-1:0]);
                            den_reg   <= PB'(srmc_pkg::RAMP_DIVISOR);
                            rem_reg   <= '0;
                            cnt_reg   <= '0;
                            ramp_div_reg <= 1'b1;
                        end
                    end
                    else if (w_reg.opcode == srmc_pkg::OP_SAMPLE && phase_reg == PH_WAIT)
                    begin
                        if (!w_reg.sample_ok)
                        begin
                            phase_reg <= PH_IDLE;
                            last_reg  <= srmc_pkg::ST_SENSOR;
                        end
                        else if (err_mag <= (AB+1)'(tol_reg))
                        begin
                            phase_reg <= PH_IDLE;
                            last_reg  <= srmc_pkg::ST_TOLERANCE;
                        end
                        else
                        begin
                            corr_dir_reg <= !err[AB+1] && err != '0;
                            prod_reg <= (AB+20)'(err_mag) * (AB+20)'(spt_reg);
                        end
                    end
                end
                S_DIV:
                begin
                    // one restoring division bit per cycle
                    num_reg <= {num_reg[DW-2:0], ~rem_sub[PB]};
                    rem_reg <= rem_sub[PB] ? rem_sh : rem_sub;
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(DW - 1))
                        seq_reg <= S_DIVEND;
                end
                S_DIVEND:
                begin
                    // quotient in num_reg, remainder in rem_reg
                    if (ramp_div_reg)
                        ramp_reg <= (num_reg[PB-1:0] == '0) ? PB'(1) : num_reg[PB-1:0];
                    else if (up_reg)
                        dly_reg <= (base_reg - 16'(num_reg[PB-1:0])
                                    - 16'(rem_reg != '0)) == 16'd0 ? 16'd1
                                   : base_reg - 16'(num_reg[PB-1:0]) - 16'(rem_reg != '0);
                    else
                        dly_reg <= (base_reg + 16'(num_reg[PB-1:0])) == 16'd0 ? 16'd1
                                   : base_reg + 16'(num_reg[PB-1:0]);
                    seq_reg <= S_OUT;
                end
                S_CORR:
                begin
                    seq_reg <= S_OUT;
                    if (corr_steps == '0)
                    begin
                        phase_reg <= PH_IDLE;
                        last_reg  <= srmc_pkg::ST_ZERO_CORR;
                    end
                    else
                    begin
                        n_reg     <= PB'(corr_steps);
                        idx_reg   <= '0;
                        dly_reg   <= (corr_delay_reg == 16'd0) ? 16'd1
                                                               : corr_delay_reg;
                        dir_reg   <= corr_dir_reg;
                        phase_reg <= PH_CORR;
                    end
                end
                default:
                begin
                    // S_OUT: load the result word once the register is free
                    if (!ovalid_reg || out_ch.ready)
                    begin
                        out_reg.step_pulse     <= pulse_reg;
                        out_reg.direction      <= dir_reg;
                        out_reg.busy_res       <= phase_reg != PH_IDLE;
                        out_reg.sample_request <= phase_reg == PH_WAIT;
                        out_reg.position_steps <= pos_reg;
                        out_reg.status         <= (phase_reg != PH_IDLE)
                                                  ? srmc_pkg::ST_WORKING : last_reg;
                        ovalid_reg <= 1'b1;
                        seq_reg    <= S_IN;
                    end
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/srmc_checker.sv =====
// srmc_checker: port-level checks for stepper_ramp_move_with_correction.
// Depends on srmc_pkg; bound to the top level below.
`timescale 1ns / 1ps
`default_nettype none
module srmc_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire srmc_pkg::out_word_t out_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");
    a_busy_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.busy_res |-> out_data.status == srmc_pkg::ST_WORKING)
        else $error("status set while busy");
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.sample_request |-> out_data.busy_res)
        else $error("sample request while idle");
    a_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("took a word while one was in flight");
endmodule

bind stepper_ramp_move_with_correction srmc_checker u_srmc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
`default_nettype wire
